// ----- hw/rtl/tsac_pkg.sv -----
// ----------------------------------------------------------------------------
// tsac_pkg
// shared types and constants of the touch sample averaging and calibration
// block: payload words, calibration registers, jobs, back-end states
// ----------------------------------------------------------------------------
package tsac_pkg;

  localparam int RAW_W   = 12;
  localparam int SUM_W   = 16;   // room for sixteen 12-bit readings
  localparam int CNT_W   = 5;    // holds a count up to sixteen
  localparam int MAG_W   = 12;   // magnitude of a difference or span
  localparam int SCALE_W = 13;   // screen size up to 4096
  localparam int DIV_W   = MAG_W + SCALE_W;

  localparam logic [RAW_W-1:0] RAW_BAD = 12'hFFF;

  localparam logic [RAW_W-1:0] X_CAL_MIN_RST = 12'd400;
  localparam logic [RAW_W-1:0] X_CAL_MAX_RST = 12'd3760;
  localparam logic [RAW_W-1:0] Y_CAL_MIN_RST = 12'd280;
  localparam logic [RAW_W-1:0] Y_CAL_MAX_RST = 12'd3660;
  localparam logic [3:0]       MIN_VALID_RST = 4'd3;

  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_PTR_W = 1;

  typedef enum logic [2:0] {
    CFG_X_CAL_MIN = 3'd0,
    CFG_X_CAL_MAX = 3'd1,
    CFG_Y_CAL_MIN = 3'd2,
    CFG_Y_CAL_MAX = 3'd3,
    CFG_MIN_VALID = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic             pen_down;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
  } in_word_t;

  typedef struct packed {
    logic             touched;
    logic [7:0]       screen_x;
    logic [8:0]       screen_y;
    logic [RAW_W-1:0] avg_x;
    logic [RAW_W-1:0] avg_y;
    logic [3:0]       valid_count;
  } out_word_t;

  typedef struct packed {
    logic [RAW_W-1:0] x_cal_min;
    logic [RAW_W-1:0] x_cal_max;
    logic [RAW_W-1:0] y_cal_min;
    logic [RAW_W-1:0] y_cal_max;
    logic [3:0]       min_valid;
  } cal_t;

  // burst = 0 marks a pen-up job
  typedef struct packed {
    logic             burst;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [CNT_W-1:0] cnt;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_AVG,
    BK_MUL,
    BK_MAP,
    BK_FIN,
    BK_OUT
  } back_state_t;

endpackage

// ----- hw/rtl/touch_sample_average_calibrate.sv -----
// ----------------------------------------------------------------------------
// touch_sample_average_calibrate
// averages bursts of raw resistive touch readings and maps them to screen
// coordinates through a linear calibration
// ----------------------------------------------------------------------------
// Push one word per converter sample (pen flag plus raw x and y); the front
// takes a word whenever the internal job queue has room, so input only
// stalls if two jobs (finished bursts or pen-up words) are already waiting.
// Each burst of SAMPLES pen-down words yields one result word, and each
// pen-up word yields an all-zero result word and drops the burst in progress.
// A burst that reports a touch passes twice through a shared bit-serial
// restoring divider in the back end (one quotient bit per cycle, 25 steps
// each, averages first, then the calibration quotients) plus a multiply
// step and bookkeeping; pen-up and rejected bursts skip the divider.
// Results wait in an output register, so while the consumer holds off the
// back end can finish one more result and then waits. Calibration registers
// sit behind a write port that is always ready and are meant to be written
// while idle.
module touch_sample_average_calibrate #(
  parameter int SAMPLES  = 8,
  parameter int SCREEN_W = 240,
  parameter int SCREEN_H = 320
) (
  input  logic                clk,
  input  logic                rst_n,
  // input word queue
  input  logic                in_push,
  output logic                in_full,
  input  tsac_pkg::in_word_t  in_word,
  // result word queue
  output logic                out_empty,
  input  logic                out_pop,
  output tsac_pkg::out_word_t out_word,
  // calibration register writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [11:0]         cfg_data
);
  import tsac_pkg::*;

  cal_t cal_r, cal_nxt;

  // jobs between the front and the back
  logic q_push, q_full, q_pop, q_empty;
  job_t q_wr_word, q_rd_word;

  // register writes never stall
  assign cfg_ready = 1'b1;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_X_CAL_MIN: cal_nxt.x_cal_min = cfg_data;
        CFG_X_CAL_MAX: cal_nxt.x_cal_max = cfg_data;
        CFG_Y_CAL_MIN: cal_nxt.y_cal_min = cfg_data;
        CFG_Y_CAL_MAX: cal_nxt.y_cal_max = cfg_data;
        CFG_MIN_VALID: cal_nxt.min_valid = cfg_data[3:0];
        // unused indexes are dropped
        default: cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r.x_cal_min <= X_CAL_MIN_RST;
      cal_r.x_cal_max <= X_CAL_MAX_RST;
      cal_r.y_cal_min <= Y_CAL_MIN_RST;
      cal_r.y_cal_max <= Y_CAL_MAX_RST;
      cal_r.min_valid <= MIN_VALID_RST;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  // front: rail rejection and burst sums
  tsac_front #(
    .SAMPLES (SAMPLES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_word (in_word),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_word  (q_wr_word)
  );

  // two-entry job queue decouples sampling from the divider
  tsac_job_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .full    (q_full),
    .wr_word (q_wr_word),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_word (q_rd_word)
  );

  // back: averages, calibration map, clamp, output register
  tsac_back #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cal       (cal_r),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_word    (q_rd_word),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

// ----- hw/rtl/tsac_front.sv -----
// ----------------------------------------------------------------------------
// tsac_front
// accepts raw words, screens out rail readings, sums a burst and hands
// finished bursts and pen-up events to the job queue
// ----------------------------------------------------------------------------
module tsac_front #(
  parameter int SAMPLES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  tsac_pkg::in_word_t in_word,
  output logic               q_push,
  input  logic               q_full,
  output tsac_pkg::job_t     q_word
);
  import tsac_pkg::*;

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SAMPLES);

  logic [SUM_W-1:0] sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;
  logic [SUM_W-1:0] add_x, add_y;
  logic [CNT_W-1:0] acc_r, acc_nxt, idx_r, idx_nxt;
  logic [CNT_W-1:0] acc_inc, idx_inc;
  logic             take, good;

  assign in_full = q_full;
  assign take    = in_push & ~q_full;

  // a pair is kept only when neither reading sits on a rail
  assign good = (in_word.raw_x != '0) && (in_word.raw_y != '0) &&
                (in_word.raw_x != RAW_BAD) && (in_word.raw_y != RAW_BAD);

  assign add_x   = sum_x_r + (good ? SUM_W'(in_word.raw_x) : '0);
  assign add_y   = sum_y_r + (good ? SUM_W'(in_word.raw_y) : '0);
  assign acc_inc = acc_r + (good ? CNT_W'(1) : '0);
  assign idx_inc = idx_r + CNT_W'(1);

  always_comb begin
    sum_x_nxt    = sum_x_r;
    sum_y_nxt    = sum_y_r;
    acc_nxt      = acc_r;
    idx_nxt      = idx_r;
    q_push       = 1'b0;
    q_word.burst = 1'b1;
    q_word.sum_x = add_x;
    q_word.sum_y = add_y;
    q_word.cnt   = acc_inc;
    if (take) begin
      if (!in_word.pen_down) begin
        q_push       = 1'b1;
        q_word.burst = 1'b0;
        sum_x_nxt    = '0;
        sum_y_nxt    = '0;
        acc_nxt      = '0;
        idx_nxt      = '0;
      end else if (idx_inc == LAST_IDX) begin
        q_push    = 1'b1;
        sum_x_nxt = '0;
        sum_y_nxt = '0;
        acc_nxt   = '0;
        idx_nxt   = '0;
      end else begin
        sum_x_nxt = add_x;
        sum_y_nxt = add_y;
        acc_nxt   = acc_inc;
        idx_nxt   = idx_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      acc_r   <= '0;
      idx_r   <= '0;
    end else begin
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      acc_r   <= acc_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ----- hw/rtl/tsac_job_queue.sv -----
// ----------------------------------------------------------------------------
// tsac_job_queue
// short first-in first-out queue of jobs between the front and the back
// ----------------------------------------------------------------------------
module tsac_job_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  tsac_pkg::job_t wr_word,
  input  logic           pop,
  output logic           empty,
  output tsac_pkg::job_t rd_word
);
  import tsac_pkg::*;

  localparam int CNTQ_W = JOBQ_PTR_W + 1;
  localparam logic [CNTQ_W-1:0] DEPTH_C = CNTQ_W'(JOBQ_DEPTH);

  job_t                  mem_r [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNTQ_W-1:0]     cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign full    = (cnt_r == DEPTH_C);
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_word = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + JOBQ_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + JOBQ_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNTQ_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNTQ_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_word;
    end
  end

endmodule

// ----- hw/rtl/tsac_back.sv -----
// ----------------------------------------------------------------------------
// tsac_back
// sequencer that turns a job into a result word: averages through a shared
// bit-serial divider, maps both axes with one multiply each and a second divider
// pass, clamps, and holds the word in an output register
// ----------------------------------------------------------------------------
module tsac_back #(
  parameter int SCREEN_W = 240,
  parameter int SCREEN_H = 320
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tsac_pkg::cal_t      cal,
  input  logic                q_empty,
  output logic                q_pop,
  input  tsac_pkg::job_t      q_word,
  output logic                out_empty,
  input  logic                out_pop,
  output tsac_pkg::out_word_t out_word
);
  import tsac_pkg::*;

  localparam logic [SCALE_W-1:0] SCALE_X = SCALE_W'(SCREEN_W);
  localparam logic [SCALE_W-1:0] SCALE_Y = SCALE_W'(SCREEN_H);
  localparam int IT_W = $clog2(DIV_W);
  localparam logic [IT_W-1:0] LAST_STEP = IT_W'(DIV_W - 1);

  // one restoring step: returns next dividend/quotient and next remainder
  function automatic logic [DIV_W+MAG_W-1:0] div_step(
    input logic [DIV_W-1:0] dv,
    input logic [MAG_W-1:0] rem,
    input logic [MAG_W-1:0] dsr
  );
    logic [MAG_W:0] rs;
    logic [MAG_W:0] diff;
    logic           ge;
    rs   = {rem, dv[DIV_W-1]};
    diff = rs - {1'b0, dsr};
    ge   = (rs >= {1'b0, dsr});
    div_step = {dv[DIV_W-2:0], ge, (ge ? diff[MAG_W-1:0] : rs[MAG_W-1:0])};
  endfunction

  function automatic logic [MAG_W-1:0] mag(input logic [MAG_W:0] v);
    logic [MAG_W:0] n;
    n   = -v;
    mag = v[MAG_W] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

  // negative or zero-span results clamp low, large ones to the last pixel
  function automatic logic [SCALE_W-1:0] clamp(
    input logic [DIV_W-1:0]   q,
    input logic               neg,
    input logic               zero,
    input logic [SCALE_W-1:0] scale
  );
    if (zero || neg) begin
      clamp = '0;
    end else if (q >= DIV_W'(scale)) begin
      clamp = scale - SCALE_W'(1);
    end else begin
      clamp = q[SCALE_W-1:0];
    end
  endfunction

  back_state_t      state_r, state_nxt;
  logic [IT_W-1:0]  it_r, it_nxt;
  logic [DIV_W-1:0] dvx_r, dvx_nxt, dvy_r, dvy_nxt;
  logic [MAG_W-1:0] remx_r, remx_nxt, remy_r, remy_nxt;
  logic [MAG_W-1:0] dsrx_r, dsrx_nxt, dsry_r, dsry_nxt;
  logic [RAW_W-1:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic [3:0]       vc_r, vc_nxt;
  logic             negx_r, negx_nxt, negy_r, negy_nxt;
  logic             zx_r, zx_nxt, zy_r, zy_nxt;
  out_word_t        res_r, res_nxt, out_r, out_nxt;
  logic             out_vld_r, out_vld_nxt;

  logic [DIV_W+MAG_W-1:0] stx, sty;
  logic [MAG_W:0]         ndx, spx, ndy, spy;
  logic [CNT_W-1:0]       need;
  logic [SCALE_W-1:0]     cx, cy;
  logic                   hit;

  assign stx = div_step(dvx_r, remx_r, dsrx_r);
  assign sty = div_step(dvy_r, remy_r, dsry_r);

  // screen x from raw y, screen y from inverted raw x
  assign ndx = {1'b0, ay_r} - {1'b0, cal.y_cal_min};
  assign spx = {1'b0, cal.y_cal_max} - {1'b0, cal.y_cal_min};
  assign ndy = {1'b0, cal.x_cal_max} - {1'b0, ax_r};
  assign spy = {1'b0, cal.x_cal_max} - {1'b0, cal.x_cal_min};

  assign need = (cal.min_valid == '0) ? CNT_W'(1) : CNT_W'(cal.min_valid);
  assign hit  = q_word.burst && (q_word.cnt >= need) && (q_word.cnt != '0);

  assign cx = clamp(dvx_r, negx_r, zx_r, SCALE_X);
  assign cy = clamp(dvy_r, negy_r, zy_r, SCALE_Y);

  assign out_empty = ~out_vld_r;
  assign out_word  = out_r;

  always_comb begin
    state_nxt   = state_r;
    it_nxt      = it_r;
    dvx_nxt     = dvx_r;
    dvy_nxt     = dvy_r;
    remx_nxt    = remx_r;
    remy_nxt    = remy_r;
    dsrx_nxt    = dsrx_r;
    dsry_nxt    = dsry_r;
    ax_nxt      = ax_r;
    ay_nxt      = ay_r;
    vc_nxt      = vc_r;
    negx_nxt    = negx_r;
    negy_nxt    = negy_r;
    zx_nxt      = zx_r;
    zy_nxt      = zy_r;
    res_nxt     = res_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r & ~out_pop;
    q_pop       = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          vc_nxt  = q_word.cnt[3:0];
          res_nxt = '0;
          if (q_word.burst) begin
            res_nxt.valid_count = q_word.cnt[3:0];
          end
          if (hit) begin
            dvx_nxt   = DIV_W'(q_word.sum_x);
            dvy_nxt   = DIV_W'(q_word.sum_y);
            remx_nxt  = '0;
            remy_nxt  = '0;
            dsrx_nxt  = MAG_W'(q_word.cnt);
            dsry_nxt  = MAG_W'(q_word.cnt);
            it_nxt    = '0;
            state_nxt = BK_AVG;
          end else begin
            state_nxt = BK_OUT;
          end
        end
      end
      BK_AVG: begin
        {dvx_nxt, remx_nxt} = stx;
        {dvy_nxt, remy_nxt} = sty;
        it_nxt = it_r + IT_W'(1);
        if (it_r == LAST_STEP) begin
          it_nxt    = '0;
          state_nxt = BK_MUL;
        end
      end
      BK_MUL: begin
        if (it_r == '0) begin
          // first cycle: latch the averages
          ax_nxt = dvx_r[RAW_W-1:0];
          ay_nxt = dvy_r[RAW_W-1:0];
          it_nxt = IT_W'(1);
        end else begin
          dvx_nxt   = DIV_W'(mag(ndx)) * DIV_W'(SCALE_X);
          dvy_nxt   = DIV_W'(mag(ndy)) * DIV_W'(SCALE_Y);
          remx_nxt  = '0;
          remy_nxt  = '0;
          dsrx_nxt  = mag(spx);
          dsry_nxt  = mag(spy);
          negx_nxt  = ndx[MAG_W] ^ spx[MAG_W];
          negy_nxt  = ndy[MAG_W] ^ spy[MAG_W];
          zx_nxt    = (spx == '0);
          zy_nxt    = (spy == '0);
          it_nxt    = '0;
          state_nxt = BK_MAP;
        end
      end
      BK_MAP: begin
        {dvx_nxt, remx_nxt} = stx;
        {dvy_nxt, remy_nxt} = sty;
        it_nxt = it_r + IT_W'(1);
        if (it_r == LAST_STEP) begin
          state_nxt = BK_FIN;
        end
      end
      BK_FIN: begin
        res_nxt.touched     = 1'b1;
        res_nxt.screen_x    = cx[7:0];
        res_nxt.screen_y    = cy[8:0];
        res_nxt.avg_x       = ax_r;
        res_nxt.avg_y       = ay_r;
        res_nxt.valid_count = vc_r;
        state_nxt           = BK_OUT;
      end
      BK_OUT: begin
        if (!out_vld_r || out_pop) begin
          out_nxt     = res_r;
          out_vld_nxt = 1'b1;
          state_nxt   = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      it_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      it_r      <= it_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvx_r  <= dvx_nxt;
    dvy_r  <= dvy_nxt;
    remx_r <= remx_nxt;
    remy_r <= remy_nxt;
    dsrx_r <= dsrx_nxt;
    dsry_r <= dsry_nxt;
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
    vc_r   <= vc_nxt;
    negx_r <= negx_nxt;
    negy_r <= negy_nxt;
    zx_r   <= zx_nxt;
    zy_r   <= zy_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

endmodule
